// ===== hw/rtl/turnout_position_monitor_assert.svh =====
// ----------------------------------------------------------------------------
// turnout position monitor assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TURNOUT_POSITION_MONITOR_ASSERT_SVH
`define TURNOUT_POSITION_MONITOR_ASSERT_SVH
`ifndef SYNTH
`define TPM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpm assertion failed");
`define TPM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpm assertion failed");
`else
`define TPM_ASSERT_IMPL(name, ante, cons)
`define TPM_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== hw/rtl/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg
// shared types and constants of the turnout position monitor
// ----------------------------------------------------------------------------
`default_nettype none
package tpm_pkg;

    localparam int TPM_TURNOUT_COUNT = 3;
    localparam int TPM_QUEUE_DEPTH   = 2;

    localparam int IDX_W   = 4;
    localparam int PWM_W   = 16;
    localparam int MS_W    = 32;
    localparam int CFG_W   = 16;
    localparam int LIMIT_W = 17;
    localparam int POS_W   = 2;
    localparam int STAT_W  = 2;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [POS_W-1:0] POS_STRAIGHT     = 2'd0;
    localparam logic [POS_W-1:0] POS_DIVERTED     = 2'd1;
    localparam logic [POS_W-1:0] POS_UNDET        = 2'd2;
    localparam logic [POS_W-1:0] POS_INCONSISTENT = 2'd3;
    localparam logic [POS_W:0]   POS_NONE         = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BLOCKED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ERROR   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE    = 2'd3;

    localparam logic [2:0] REG_RESEND   = 3'd0;
    localparam logic [2:0] REG_MOVE_MIN = 3'd1;
    localparam logic [2:0] REG_MOVE_MAX = 3'd2;
    localparam logic [2:0] REG_MARGIN   = 3'd3;
    localparam logic [2:0] REG_FALLBACK = 3'd4;

    localparam logic [CFG_W-1:0] RST_RESEND   = 16'd200;
    localparam logic [CFG_W-1:0] RST_MOVE_MIN = 16'd200;
    localparam logic [CFG_W-1:0] RST_MOVE_MAX = 16'd1500;
    localparam logic [CFG_W-1:0] RST_MARGIN   = 16'd200;
    localparam logic [CFG_W-1:0] RST_FALLBACK = 16'd800;

    typedef struct packed {
        logic [CFG_W-1:0] resend_period_ms;
        logic [CFG_W-1:0] move_time_min_ms;
        logic [CFG_W-1:0] move_time_max_ms;
        logic [CFG_W-1:0] move_margin_ms;
        logic [CFG_W-1:0] fallback_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [IDX_W-1:0]   idx;
        logic [POS_W-1:0]   pos;
        logic [LIMIT_W-1:0] limit;
        logic [MS_W-1:0]    now;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

// ===== hw/rtl/tpm_if.sv =====
// ----------------------------------------------------------------------------
// tpm channel interfaces
// valid/ready channels for input items and reports
// ----------------------------------------------------------------------------
`default_nettype none
interface tpm_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [tpm_pkg::IDX_W-1:0]  turnout_index;
    logic                       straight_contact_level;
    logic                       diverted_contact_level;
    logic [tpm_pkg::PWM_W-1:0]  cur_pulse;
    logic [tpm_pkg::PWM_W-1:0]  tgt_pulse;
    logic [tpm_pkg::MS_W-1:0]   now_ms;

    modport source (
        output valid, mode, turnout_index, straight_contact_level,
        output diverted_contact_level, cur_pulse, tgt_pulse, now_ms,
        input  ready
    );
    modport sink (
        input  valid, mode, turnout_index, straight_contact_level,
        input  diverted_contact_level, cur_pulse, tgt_pulse, now_ms,
        output ready
    );
endinterface

interface tpm_out_if;
    logic                       valid;
    logic                       ready;
    logic [tpm_pkg::IDX_W-1:0]  report_index;
    logic [tpm_pkg::POS_W-1:0]  report_position;
    logic [tpm_pkg::STAT_W-1:0] report_status;

    modport source (
        output valid, report_index, report_position, report_status,
        input  ready
    );
    modport sink (
        input  valid, report_index, report_position, report_status,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/turnout_position_monitor.sv =====
// ----------------------------------------------------------------------------
// turnout_position_monitor
// position and stall monitor for servo-driven rail turnouts
// ----------------------------------------------------------------------------
//  channel   dir   handshake     beat
//  i_in      in    valid/ready   sample or movement start
//  o_out     out   valid/ready   position report
//  apb       in    psel/penable  register write or read
//
//  one item per cycle while the queue is not full; the front decodes and
//  computes the limit in the cycle of acceptance and pushes into a two-entry
//  queue, from which the back pops to update the turnout state and to load
//  the report register; a stalled report holds the back and the front keeps
//  taking beats until the queue is full
//  synchronous active-low reset clears all turnout state and registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "turnout_position_monitor_assert.svh"
module turnout_position_monitor #(
    parameter int TURNOUT_COUNT = tpm_pkg::TPM_TURNOUT_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tpm_in_if.sink                        i_in,
    tpm_out_if.source                     o_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [tpm_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [tpm_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [tpm_pkg::PDATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    import tpm_pkg::*;

    t_cfg   r_cfg;
    logic   w_wr;
    logic   w_push;
    logic   w_pop;
    t_qent  w_push_ent;
    t_qent  w_head;
    t_qstat w_qstat;
    logic   w_out_bad_pos;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resend_period_ms  <= RST_RESEND;
            r_cfg.move_time_min_ms  <= RST_MOVE_MIN;
            r_cfg.move_time_max_ms  <= RST_MOVE_MAX;
            r_cfg.move_margin_ms    <= RST_MARGIN;
            r_cfg.fallback_limit_ms <= RST_FALLBACK;
        end else if (w_wr) begin
            case (i_paddr[4:2])
                REG_RESEND:   r_cfg.resend_period_ms  <= i_pwdata[CFG_W-1:0];
                REG_MOVE_MIN: r_cfg.move_time_min_ms  <= i_pwdata[CFG_W-1:0];
                REG_MOVE_MAX: r_cfg.move_time_max_ms  <= i_pwdata[CFG_W-1:0];
                REG_MARGIN:   r_cfg.move_margin_ms    <= i_pwdata[CFG_W-1:0];
                REG_FALLBACK: r_cfg.fallback_limit_ms <= i_pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (i_paddr[4:2])
            REG_RESEND:   o_prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.resend_period_ms};
            REG_MOVE_MIN: o_prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.move_time_min_ms};
            REG_MOVE_MAX: o_prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.move_time_max_ms};
            REG_MARGIN:   o_prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.move_margin_ms};
            REG_FALLBACK: o_prdata = {{(PDATA_W-CFG_W){1'b0}}, r_cfg.fallback_limit_ms};
            default:      o_prdata = '0;
        endcase
    end

    tpm_front #(
        .TURNOUT_COUNT(TURNOUT_COUNT)
    ) u_front (
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_ent   (w_push_ent)
    );

    tpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    tpm_back #(
        .TURNOUT_COUNT(TURNOUT_COUNT)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_resend_period_ms (r_cfg.resend_period_ms),
        .i_head             (w_head),
        .i_qstat            (w_qstat),
        .o_pop              (w_pop),
        .o_out              (o_out)
    );

    assign w_out_bad_pos = o_out.valid &&
                           ((o_out.report_position == POS_UNDET) ||
                            (o_out.report_position == POS_INCONSISTENT));

    `TPM_ASSERT_IMPL(a_push_in_range, w_push, {1'b0, w_push_ent.idx} < (IDX_W+1)'(TURNOUT_COUNT))
    `TPM_ASSERT_IMPL(a_pop_not_empty, w_pop, !w_qstat.empty)
    `TPM_ASSERT_IMPL(a_bad_pos_is_error, w_out_bad_pos, o_out.report_status == STAT_ERROR)

endmodule
`default_nettype wire

// ===== hw/rtl/tpm_front.sv =====
// ----------------------------------------------------------------------------
// tpm_front
// accepts input beats, drops bad indices, decodes contacts, computes limits
// ----------------------------------------------------------------------------
`default_nettype none
module tpm_front #(
    parameter int TURNOUT_COUNT = tpm_pkg::TPM_TURNOUT_COUNT
) (
    tpm_in_if.sink          i_in,
    input  tpm_pkg::t_cfg   i_cfg,
    input  tpm_pkg::t_qstat i_qstat,
    output logic            o_push,
    output tpm_pkg::t_qent  o_ent
);
    import tpm_pkg::*;

    logic             w_in_range;
    logic             w_s_pressed;
    logic             w_d_pressed;
    logic [PWM_W-1:0] w_span;
    logic [PWM_W-1:0] w_half;
    logic [PWM_W-1:0] w_lo;
    logic [PWM_W-1:0] w_clamped;
    logic [LIMIT_W-1:0] w_limit;
    logic [POS_W-1:0] w_pos;

    assign i_in.ready = !i_qstat.full;
    assign w_in_range = {1'b0, i_in.turnout_index} < (IDX_W+1)'(TURNOUT_COUNT);
    assign o_push     = i_in.valid && !i_qstat.full && w_in_range;

    // contact decode, active low
    assign w_s_pressed = !i_in.straight_contact_level;
    assign w_d_pressed = !i_in.diverted_contact_level;

    always_comb begin
        if (w_s_pressed && !w_d_pressed) begin
            w_pos = POS_STRAIGHT;
        end else if (!w_s_pressed && w_d_pressed) begin
            w_pos = POS_DIVERTED;
        end else if (!w_s_pressed && !w_d_pressed) begin
            w_pos = POS_UNDET;
        end else begin
            w_pos = POS_INCONSISTENT;
        end
    end

    // stall limit estimate
    always_comb begin
        if (i_in.cur_pulse > i_in.tgt_pulse) begin
            w_span = i_in.cur_pulse - i_in.tgt_pulse;
        end else begin
            w_span = i_in.tgt_pulse - i_in.cur_pulse;
        end
        w_half    = w_span >> 1;
        w_lo      = (w_half < i_cfg.move_time_min_ms) ? i_cfg.move_time_min_ms : w_half;
        w_clamped = (w_lo > i_cfg.move_time_max_ms) ? i_cfg.move_time_max_ms : w_lo;
        if (i_in.cur_pulse == '0 || i_in.tgt_pulse == '0) begin
            w_limit = {1'b0, i_cfg.fallback_limit_ms};
        end else begin
            w_limit = {1'b0, w_clamped} + {1'b0, i_cfg.move_margin_ms};
        end
    end

    always_comb begin
        o_ent.mode  = i_in.mode;
        o_ent.idx   = i_in.turnout_index;
        o_ent.pos   = w_pos;
        o_ent.limit = w_limit;
        o_ent.now   = i_in.now_ms;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tpm_queue.sv =====
// ----------------------------------------------------------------------------
// tpm_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module tpm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tpm_pkg::t_qent  i_ent,
    input  logic            i_pop,
    output tpm_pkg::t_qent  o_head,
    output tpm_pkg::t_qstat o_qstat
);
    import tpm_pkg::*;

    localparam int PTR_W = (TPM_QUEUE_DEPTH > 1) ? $clog2(TPM_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TPM_QUEUE_DEPTH + 1);

    t_qent            r_mem [TPM_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(TPM_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(TPM_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_ent;
        end
    end

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == CNT_W'(TPM_QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/tpm_back.sv =====
// ----------------------------------------------------------------------------
// tpm_back
// per-turnout state update and report register
// ----------------------------------------------------------------------------
`default_nettype none
module tpm_back #(
    parameter int TURNOUT_COUNT = tpm_pkg::TPM_TURNOUT_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tpm_pkg::CFG_W-1:0]   i_resend_period_ms,
    input  tpm_pkg::t_qent              i_head,
    input  tpm_pkg::t_qstat             i_qstat,
    output logic                        o_pop,
    tpm_out_if.source                   o_out
);
    import tpm_pkg::*;

    localparam int IW = (TURNOUT_COUNT > 1) ? $clog2(TURNOUT_COUNT) : 1;

    logic [POS_W:0]     r_last_pos  [TURNOUT_COUNT];
    logic [STAT_W-1:0]  r_last_stat [TURNOUT_COUNT];
    logic [MS_W-1:0]    r_last_ms   [TURNOUT_COUNT];
    logic [MS_W-1:0]    r_start_ms  [TURNOUT_COUNT];
    logic [LIMIT_W-1:0] r_limit_ms  [TURNOUT_COUNT];
    logic               r_active    [TURNOUT_COUNT];

    logic               r_out_valid;
    logic [IDX_W-1:0]   r_out_idx;
    logic [POS_W-1:0]   r_out_pos;
    logic [STAT_W-1:0]  r_out_stat;

    logic [IW-1:0]      w_hi;
    logic [MS_W-1:0]    w_move_elapsed;
    logic [MS_W-1:0]    w_report_elapsed;
    logic               w_pos_valid;
    logic [STAT_W-1:0]  w_stat;
    logic               w_changed;
    logic               w_periodic;
    logic               w_emit;

    assign w_hi  = i_head.idx[IW-1:0];
    assign o_pop = !i_qstat.empty && (!r_out_valid || o_out.ready);

    assign w_move_elapsed   = i_head.now - r_start_ms[w_hi];
    assign w_report_elapsed = i_head.now - r_last_ms[w_hi];
    assign w_pos_valid      = (i_head.pos == POS_STRAIGHT) || (i_head.pos == POS_DIVERTED);

    always_comb begin
        if (!w_pos_valid) begin
            w_stat = STAT_ERROR;
        end else if (r_active[w_hi] &&
                     (w_move_elapsed > {{(MS_W-LIMIT_W){1'b0}}, r_limit_ms[w_hi]})) begin
            w_stat = STAT_BLOCKED;
        end else begin
            w_stat = STAT_OK;
        end
    end

    assign w_changed  = ({1'b0, i_head.pos} != r_last_pos[w_hi]) ||
                        (w_stat != r_last_stat[w_hi]);
    assign w_periodic = w_report_elapsed >= {{(MS_W-CFG_W){1'b0}}, i_resend_period_ms};
    assign w_emit     = o_pop && !i_head.mode && (w_changed || w_periodic);

    // turnout state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TURNOUT_COUNT; i++) begin
                r_last_pos[i]  <= POS_NONE;
                r_last_stat[i] <= STAT_NONE;
                r_last_ms[i]   <= '0;
                r_start_ms[i]  <= '0;
                r_limit_ms[i]  <= '0;
                r_active[i]    <= 1'b0;
            end
        end else if (o_pop) begin
            if (i_head.mode) begin
                r_active[w_hi]   <= 1'b1;
                r_start_ms[w_hi] <= i_head.now;
                r_limit_ms[w_hi] <= i_head.limit;
            end else begin
                if (w_pos_valid && w_stat == STAT_OK) begin
                    r_active[w_hi] <= 1'b0;
                end
                if (w_emit) begin
                    r_last_pos[w_hi]  <= {1'b0, i_head.pos};
                    r_last_stat[w_hi] <= w_stat;
                    r_last_ms[w_hi]   <= i_head.now;
                end
            end
        end
    end

    // report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_idx  <= i_head.idx;
            r_out_pos  <= i_head.pos;
            r_out_stat <= w_stat;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.report_index    = r_out_idx;
    assign o_out.report_position = r_out_pos;
    assign o_out.report_status   = r_out_stat;

endmodule
`default_nettype wire

// ===== tb/sv/turnout_position_monitor_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// turnout_position_monitor_tb
// sends sample and movement-start beats with random gaps, keeps its own copy
// of the turnout table to work out each position report, and compares every
// report beat field by field; the registers change between phases while the
// block is idle, and the report side is held off long enough to stall input
// ----------------------------------------------------------------------------
module turnout_position_monitor_tb;
    import tpm_pkg::*;

    localparam int CLK_HALF_NS        = 5;
    localparam int RESET_CYCLES       = 5;
    localparam int SETTLE_CYCLES      = 8;
    localparam int REPORT_HOLD_CYCLES = 64;
    localparam int MAX_SHOWN          = 10;
    localparam int LIMIT_NS           = 2_000_000;
    localparam int IDX_MAX            = (1 << IDX_W) - 1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_MOVE   = 1'b1;
    localparam logic PRESSED     = 1'b0;
    localparam logic RELEASED    = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] idx;
        logic             straight_lvl;
        logic             diverted_lvl;
        logic [PWM_W-1:0] cur_pwm;
        logic [PWM_W-1:0] tgt_pwm;
        logic [MS_W-1:0]  now;
    } t_turnout_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [POS_W-1:0]  pos;
        logic [STAT_W-1:0] stat;
    } t_report;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tpm_in_if  in_if ();
    tpm_out_if out_if ();

    turnout_position_monitor dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // shadow of registers and turnout table
    t_cfg               cfg;
    logic [POS_W:0]     sent_pos   [TPM_TURNOUT_COUNT];
    logic [STAT_W-1:0]  sent_stat  [TPM_TURNOUT_COUNT];
    logic [MS_W-1:0]    sent_ms    [TPM_TURNOUT_COUNT];
    logic [MS_W-1:0]    move_start [TPM_TURNOUT_COUNT];
    logic [LIMIT_W-1:0] move_limit [TPM_TURNOUT_COUNT];
    logic               moving     [TPM_TURNOUT_COUNT];

    t_report         pending_reports[$];
    int              fail_count      = 0;
    bit              src_idle_en     = 1'b1;
    bit              sink_idle_en    = 1'b1;
    bit              report_hold_req = 1'b0;
    int              report_gap      = 0;
    logic [MS_W-1:0] clock_ms        = '0;

    function automatic void clear_turnout_table();
        cfg.resend_period_ms  = RST_RESEND;
        cfg.move_time_min_ms  = RST_MOVE_MIN;
        cfg.move_time_max_ms  = RST_MOVE_MAX;
        cfg.move_margin_ms    = RST_MARGIN;
        cfg.fallback_limit_ms = RST_FALLBACK;
        for (int i = 0; i < TPM_TURNOUT_COUNT; i++) begin
            sent_pos[i]   = POS_NONE;
            sent_stat[i]  = STAT_NONE;
            sent_ms[i]    = '0;
            move_start[i] = '0;
            move_limit[i] = '0;
            moving[i]     = 1'b0;
        end
    endfunction

    function automatic logic [LIMIT_W-1:0] stall_budget(input logic [PWM_W-1:0] cur,
                                                        input logic [PWM_W-1:0] tgt);
        logic [PWM_W-1:0] t;
        if (cur == '0 || tgt == '0) begin
            return LIMIT_W'(cfg.fallback_limit_ms);
        end
        t = (cur > tgt) ? (cur - tgt) : (tgt - cur);
        t = t >> 1;
        if (t < cfg.move_time_min_ms) t = cfg.move_time_min_ms;
        if (t > cfg.move_time_max_ms) t = cfg.move_time_max_ms;
        return LIMIT_W'(t) + LIMIT_W'(cfg.move_margin_ms);
    endfunction

    function automatic logic [POS_W-1:0] contact_position(input logic straight_lvl,
                                                          input logic diverted_lvl);
        if (straight_lvl == PRESSED && diverted_lvl == RELEASED) return POS_STRAIGHT;
        if (straight_lvl == RELEASED && diverted_lvl == PRESSED) return POS_DIVERTED;
        if (straight_lvl == RELEASED && diverted_lvl == RELEASED) return POS_UNDET;
        return POS_INCONSISTENT;
    endfunction

    // update the table for one accepted beat and queue the report it causes
    function automatic void track_turnout(input t_turnout_cmd c);
        logic [POS_W-1:0]  pos;
        logic [STAT_W-1:0] stat;
        logic [MS_W-1:0]   run_ms;
        logic [MS_W-1:0]   since_ms;
        t_report           r;
        int                i;
        if (c.idx >= TPM_TURNOUT_COUNT) return;
        i = c.idx;
        if (c.mode == MODE_MOVE) begin
            moving[i]     = 1'b1;
            move_start[i] = c.now;
            move_limit[i] = stall_budget(c.cur_pwm, c.tgt_pwm);
            return;
        end
        pos    = contact_position(c.straight_lvl, c.diverted_lvl);
        run_ms = c.now - move_start[i];
        if (pos == POS_UNDET || pos == POS_INCONSISTENT) begin
            stat = STAT_ERROR;
        end else if (moving[i] && run_ms > MS_W'(move_limit[i])) begin
            stat = STAT_BLOCKED;
        end else begin
            stat = STAT_OK;
        end
        if (stat == STAT_OK) moving[i] = 1'b0;
        since_ms = c.now - sent_ms[i];
        if ({1'b0, pos} != sent_pos[i] || stat != sent_stat[i] ||
            since_ms >= MS_W'(cfg.resend_period_ms)) begin
            sent_ms[i]   = c.now;
            sent_pos[i]  = {1'b0, pos};
            sent_stat[i] = stat;
            r.idx  = c.idx;
            r.pos  = pos;
            r.stat = stat;
            pending_reports.push_back(r);
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_report want,
                                          input t_report got);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("%0t %s: want idx %0d pos %0d stat %0d, got idx %0d pos %0d stat %0d",
                     $time, what, want.idx, want.pos, want.stat, got.idx, got.pos, got.stat);
        end
    endfunction

    always @(posedge i_clk) begin : report_check
        t_report got;
        t_report want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            report_gap = sink_idle_en ? $urandom_range(0, 3) : 0;
            got.idx  = out_if.report_index;
            got.pos  = out_if.report_position;
            got.stat = out_if.report_status;
            if (pending_reports.size() == 0) begin
                note_mismatch("report beat with none pending", '0, got);
            end else begin
                want = pending_reports.pop_front();
                if (got.idx !== want.idx || got.pos !== want.pos || got.stat !== want.stat) begin
                    note_mismatch("report mismatch", want, got);
                end
            end
        end
    end

    // report side: random gaps per beat, plus a long hold on request
    initial begin : report_sink
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (report_hold_req) begin
                report_hold_req = 1'b0;
                out_if.ready    = 1'b0;
                repeat (REPORT_HOLD_CYCLES) @(negedge i_clk);
            end
            if (report_gap > 0) begin
                out_if.ready = 1'b0;
                report_gap--;
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    task automatic send_item(input t_turnout_cmd c);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.mode                   = c.mode;
        in_if.turnout_index          = c.idx;
        in_if.straight_contact_level = c.straight_lvl;
        in_if.diverted_contact_level = c.diverted_lvl;
        in_if.cur_pulse              = c.cur_pwm;
        in_if.tgt_pulse              = c.tgt_pwm;
        in_if.now_ms                 = c.now;
        in_if.valid                  = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        track_turnout(c);
        @(negedge i_clk);
    endtask

    task automatic wait_reports_drained();
        in_if.valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] sel, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = PDATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (sel)
            REG_RESEND:   cfg.resend_period_ms  = value;
            REG_MOVE_MIN: cfg.move_time_min_ms  = value;
            REG_MOVE_MAX: cfg.move_time_max_ms  = value;
            REG_MARGIN:   cfg.move_margin_ms    = value;
            REG_FALLBACK: cfg.fallback_limit_ms = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] resend, input logic [CFG_W-1:0] lo,
                                  input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] margin,
                                  input logic [CFG_W-1:0] fallback);
        wait_reports_drained();
        write_reg(REG_RESEND, resend);
        write_reg(REG_MOVE_MIN, lo);
        write_reg(REG_MOVE_MAX, hi);
        write_reg(REG_MARGIN, margin);
        write_reg(REG_FALLBACK, fallback);
    endtask

    function automatic t_turnout_cmd sample_cmd(input int idx, input logic straight_lvl,
                                                input logic diverted_lvl,
                                                input logic [MS_W-1:0] now);
        t_turnout_cmd c;
        c.mode         = MODE_SAMPLE;
        c.idx          = IDX_W'(idx);
        c.straight_lvl = straight_lvl;
        c.diverted_lvl = diverted_lvl;
        c.cur_pwm      = PWM_W'($urandom);
        c.tgt_pwm      = PWM_W'($urandom);
        c.now          = now;
        return c;
    endfunction

    function automatic t_turnout_cmd move_cmd(input int idx, input logic [PWM_W-1:0] cur,
                                              input logic [PWM_W-1:0] tgt,
                                              input logic [MS_W-1:0] now);
        t_turnout_cmd c;
        c.mode         = MODE_MOVE;
        c.idx          = IDX_W'(idx);
        c.straight_lvl = 1'($urandom);
        c.diverted_lvl = 1'($urandom);
        c.cur_pwm      = cur;
        c.tgt_pwm      = tgt;
        c.now          = now;
        return c;
    endfunction

    // mostly a forward-running clock with moves and settled samples,
    // some jumps, far turnouts and odd contact pairs mixed in
    function automatic t_turnout_cmd random_cmd();
        t_turnout_cmd c;
        int           r;
        r = $urandom_range(0, 99);
        if (r < 60) clock_ms += $urandom_range(0, 60);
        else if (r < 85) clock_ms += $urandom_range(0, 2500);
        else if (r < 96) clock_ms += $urandom_range(0, 140000);
        else clock_ms = $urandom;
        c.now = clock_ms;
        c.idx = ($urandom_range(0, 99) < 88) ? IDX_W'($urandom_range(0, TPM_TURNOUT_COUNT - 1))
                                              : IDX_W'($urandom_range(TPM_TURNOUT_COUNT, IDX_MAX));
        c.mode = ($urandom_range(0, 99) < 22) ? MODE_MOVE : MODE_SAMPLE;
        r = $urandom_range(0, 99);
        if (r < 40) {c.straight_lvl, c.diverted_lvl} = {PRESSED, RELEASED};
        else if (r < 70) {c.straight_lvl, c.diverted_lvl} = {RELEASED, PRESSED};
        else if (r < 90) {c.straight_lvl, c.diverted_lvl} = {RELEASED, RELEASED};
        else {c.straight_lvl, c.diverted_lvl} = {PRESSED, PRESSED};
        c.cur_pwm = PWM_W'($urandom);
        c.tgt_pwm = PWM_W'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0) c.cur_pwm = '0;
        else if (r == 1) c.tgt_pwm = '0;
        else if (r < 5) c.tgt_pwm = c.cur_pwm + PWM_W'($urandom_range(0, 3000));
        return c;
    endfunction

    task automatic run_random(input int count);
        repeat (count) send_item(random_cmd());
    endtask

    task automatic test_contact_decode();
        send_item(sample_cmd(0, PRESSED, RELEASED, 32'd1000));
        send_item(sample_cmd(0, PRESSED, RELEASED, 32'd1001));
        send_item(sample_cmd(0, RELEASED, PRESSED, 32'd1002));
        send_item(sample_cmd(0, RELEASED, RELEASED, 32'd1003));
        send_item(sample_cmd(0, PRESSED, PRESSED, 32'd1004));
        send_item(sample_cmd(2, PRESSED, PRESSED, 32'd1005));
        send_item(sample_cmd(1, RELEASED, RELEASED, 32'hFFFF_FFFF));
        // out-of-range turnouts change nothing
        send_item(sample_cmd(TPM_TURNOUT_COUNT, PRESSED, RELEASED, 32'd0));
        send_item(sample_cmd(IDX_MAX, RELEASED, PRESSED, 32'hFFFF_FFFF));
        send_item(move_cmd(IDX_MAX, 16'hFFFF, 16'hFFFF, 32'd5));
        // unchanged state resent once the period has run out
        send_item(sample_cmd(0, PRESSED, PRESSED, 32'd1204));
    endtask

    task automatic test_stall_timer();
        logic [MS_W-1:0] t0;
        t0 = 32'd50_000;
        // zero pulse value uses the fallback limit
        send_item(move_cmd(1, 16'd0, 16'd1500, t0));
        send_item(sample_cmd(1, PRESSED, RELEASED, t0 + 800));
        send_item(move_cmd(1, 16'd1500, 16'd0, t0 + 1000));
        send_item(sample_cmd(1, RELEASED, RELEASED, t0 + 1500));
        send_item(sample_cmd(1, RELEASED, PRESSED, t0 + 1801));
        // re-arm restarts the timer with a new limit
        send_item(move_cmd(1, 16'd1000, 16'd1000, t0 + 1900));
        send_item(sample_cmd(1, RELEASED, PRESSED, t0 + 2200));
        // widest span clamps high, elapsed time wraps
        send_item(move_cmd(2, 16'hFFFF, 16'd1, 32'hFFFF_FE00));
        send_item(sample_cmd(2, PRESSED, RELEASED, 32'hFFFF_FE00 + 1701));
        send_item(move_cmd(0, 16'd1, 16'hFFFF, t0 + 3000));
        send_item(sample_cmd(0, PRESSED, RELEASED, t0 + 3100));
        send_item(move_cmd(0, 16'd700, 16'd1100, t0 + 4000));
        send_item(sample_cmd(0, RELEASED, PRESSED, t0 + 4401));
        clock_ms = t0 + 5000;
    endtask

    task automatic test_clamp_extremes();
        apply_settings(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(220);
        // crossed clamps: the upper one wins
        apply_settings(16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        run_random(220);
    endtask

    task automatic test_zero_resend();
        apply_settings(16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
        run_random(150);
    endtask

    task automatic test_random_settings();
        for (int k = 0; k < 3; k++) begin
            if (k < 2) begin
                apply_settings(CFG_W'($urandom_range(1, 3000)), CFG_W'($urandom_range(0, 1000)),
                               CFG_W'($urandom_range(0, 4000)), CFG_W'($urandom_range(0, 1000)),
                               CFG_W'($urandom_range(0, 3000)));
            end else begin
                apply_settings(CFG_W'($urandom_range(1, 65535)), CFG_W'($urandom),
                               CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
            end
            run_random(180);
        end
    endtask

    task automatic test_steady_flow();
        apply_settings(RST_RESEND, RST_MOVE_MIN, RST_MOVE_MAX, RST_MARGIN, RST_FALLBACK);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_random(150);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_report_backpressure();
        apply_settings(16'd1, RST_MOVE_MIN, RST_MOVE_MAX, RST_MARGIN, RST_FALLBACK);
        src_idle_en     = 1'b0;
        report_hold_req = 1'b1;
        // every beat reports, so the queue fills while reports are held
        for (int k = 0; k < 32; k++) begin
            clock_ms += 1;
            send_item(sample_cmd(k % TPM_TURNOUT_COUNT, logic'(k[1]), logic'(~k[1]), clock_ms));
        end
        src_idle_en = 1'b1;
        wait_reports_drained();
        run_random(150);
    endtask

    initial begin : run_tests
        in_if.valid                  = 1'b0;
        in_if.mode                   = MODE_SAMPLE;
        in_if.turnout_index          = '0;
        in_if.straight_contact_level = RELEASED;
        in_if.diverted_contact_level = RELEASED;
        in_if.cur_pulse              = '0;
        in_if.tgt_pulse              = '0;
        in_if.now_ms                 = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        clear_turnout_table();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_contact_decode();
        test_stall_timer();
        test_clamp_extremes();
        test_zero_resend();
        test_random_settings();
        test_steady_flow();
        test_report_backpressure();

        wait_reports_drained();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tpm_pkg.sv
hw/rtl/tpm_if.sv
hw/rtl/tpm_front.sv
hw/rtl/tpm_queue.sv
hw/rtl/tpm_back.sv
hw/rtl/turnout_position_monitor.sv
tb/sv/turnout_position_monitor_tb.sv
